// ----- hdl/assert_macros.svh -----
// Assertion macros used by the scorer core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("check failed");
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("check failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ----- hdl/ats_pkg.sv -----
package ats_pkg;
  localparam int DIM           = 64;
  localparam int NUM_ENTITIES  = 1024;
  localparam int NUM_RELATIONS = 64;
  localparam int DIM_W  = $clog2(DIM);
  localparam int ENT_AW = $clog2(NUM_ENTITIES * DIM);
  localparam int REL_AW = $clog2(NUM_RELATIONS * DIM);

  localparam logic [1:0] FN_WENT  = 2'd0;
  localparam logic [1:0] FN_WREL  = 2'd1;
  localparam logic [1:0] FN_SCORE = 2'd2;
  localparam logic [1:0] FN_GRAD  = 2'd3;

  localparam logic CFG_SCALAR = 1'b0;
  localparam logic CFG_PAIR   = 1'b1;

  typedef logic signed [15:0] word_t;

  typedef struct packed {
    logic own_ld;
    logic prod_en;
    logic sum_en;
    logic im;
    logic s_keep;
    logic r_keep;
    logic o_keep;
  } ats_ctl_t;
endpackage

// ----- hdl/ats_tables.sv -----
module ats_tables (
  input  logic                        clk,
  input  logic                        we_ent,
  input  logic                        we_rel,
  input  logic [ats_pkg::ENT_AW-1:0]  wa_ent,
  input  logic [ats_pkg::REL_AW-1:0]  wa_rel,
  input  ats_pkg::word_t              wdata,
  input  logic [ats_pkg::ENT_AW-1:0]  ra_s,
  input  logic [ats_pkg::ENT_AW-1:0]  ra_o,
  input  logic [ats_pkg::REL_AW-1:0]  ra_r,
  output ats_pkg::word_t              rd_s,
  output ats_pkg::word_t              rd_o,
  output ats_pkg::word_t              rd_r
);
  import ats_pkg::*;

  word_t ent_mem [NUM_ENTITIES*DIM];
  word_t rel_mem [NUM_RELATIONS*DIM];

  always_ff @(posedge clk) begin
    if (we_ent) begin
      ent_mem[wa_ent] <= wdata;
    end
    rd_s <= ent_mem[ra_s];
    rd_o <= ent_mem[ra_o];
  end

  always_ff @(posedge clk) begin
    if (we_rel) begin
      rel_mem[wa_rel] <= wdata;
    end
    rd_r <= rel_mem[ra_r];
  end
endmodule

// ----- hdl/ats_datapath.sv -----
module ats_datapath (
  input  logic                     clk,
  input  ats_pkg::ats_ctl_t        ctl,
  input  ats_pkg::word_t           rd_s,
  input  ats_pkg::word_t           rd_o,
  input  ats_pkg::word_t           rd_r,
  output logic signed [32:0]       gs,
  output logic signed [32:0]       gr,
  output logic signed [32:0]       go,
  output logic signed [47:0]       t1,
  output logic signed [47:0]       t2
);
  import ats_pkg::*;

  word_t so, ro, oo, op;
  word_t sp_w, rp_w, op_w;
  logic signed [31:0] ro_oo, rp_op, rp_oo, ro_op;
  logic signed [31:0] so_oo, sp_op, sp_oo, so_op;
  logic signed [31:0] ro_so, rp_sp, rp_so, ro_sp;

  assign sp_w = ctl.s_keep ? rd_s : '0;
  assign rp_w = ctl.r_keep ? rd_r : '0;
  assign op_w = ctl.o_keep ? rd_o : '0;

  always_ff @(posedge clk) begin
    if (ctl.own_ld) begin
      so <= sp_w;
      ro <= rp_w;
      oo <= op_w;
    end
    if (ctl.prod_en) begin
      op    <= op_w;
      ro_oo <= ro * oo;
      rp_op <= rp_w * op_w;
      rp_oo <= rp_w * oo;
      ro_op <= ro * op_w;
      so_oo <= so * oo;
      sp_op <= sp_w * op_w;
      sp_oo <= sp_w * oo;
      so_op <= so * op_w;
      ro_so <= ro * so;
      rp_sp <= rp_w * sp_w;
      rp_so <= rp_w * so;
      ro_sp <= ro * sp_w;
    end
    if (ctl.sum_en) begin
      if (ctl.im) begin
        gs <= 33'(rp_oo) - 33'(ro_op);
        gr <= 33'(sp_oo) - 33'(so_op);
        go <= 33'(rp_so) + 33'(ro_sp);
        t1 <= 48'(ro_sp) * 48'(oo);
        t2 <= 48'(ro_so) * 48'(op);
      end else begin
        gs <= 33'(ro_oo) + 33'(rp_op);
        gr <= 33'(so_oo) + 33'(sp_op);
        go <= 33'(ro_so) - 33'(rp_sp);
        t1 <= 48'(ro_so) * 48'(oo);
        t2 <= 48'(ro_sp) * 48'(op);
      end
    end
  end
endmodule

// ----- hdl/analogy_triple_scorer_core.sv -----
// Trilinear knowledge graph scorer with real and complex embedding dimensions.
// The configuration channel writes scalar_count (index 0) and pair_count (index 1)
// and is always ready. An input beat with func 0 or 1 writes one word into the
// entity or relation table in the same cycle and gives no result.
// A score beat gives one result beat with the full precision score. A gradient
// beat gives one result beat per dimension, in dimension order, the final one
// marked by last. If scalar_count plus twice pair_count exceeds the embedding
// width, a query gives a single result beat with status set.
// Each dimension steps through the states own, partner, multiply, sum and emit:
// the table memories are read twice (own and partner dimension), then products,
// sums and the result stage follow. An error query goes straight to the result
// stage without reading the tables. The next input beat can be taken in the cycle
// after the last result is registered. Input is taken only between queries.
// A stalled result holds in the output register; a gradient query pauses until the
// register frees. Reset clears control state, sets scalar_count 0 and pair_count
// 32; the table contents are not cleared and must be written before they are read.
module analogy_triple_scorer_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [6:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          func,
  input  logic [9:0]          subj,
  input  logic [5:0]          rel,
  input  logic [9:0]          obj,
  input  logic [5:0]          column,
  input  logic signed [15:0]  value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [53:0]  score_sum,
  output logic signed [32:0]  grad_subj,
  output logic signed [32:0]  grad_rel,
  output logic signed [32:0]  grad_obj,
  output logic [5:0]          dim_index,
  output logic                last,
  output logic                status
);
  import ats_pkg::*;
  `include "assert_macros.svh"

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_OWN  = 3'd1;
  localparam logic [2:0] ST_PAR  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_SUM  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0]       state;
  logic [6:0]       scalar_count;
  logic [5:0]       pair_count;
  logic             is_grad, err, im, own_zero, par_zero;
  logic             s_ok, r_ok, o_ok;
  logic [9:0]       subj_q, obj_q;
  logic [5:0]       rel_q;
  logic [DIM_W-1:0] dim, par_col;
  logic signed [53:0] acc;

  logic [7:0] used, dd, mid, partner;
  logic       over, in_fire, out_free, dim_last;
  logic [DIM_W-1:0] rcol;
  logic signed [48:0] term;
  logic signed [53:0] acc_next;
  ats_ctl_t ctl;
  word_t rd_s, rd_o, rd_r;
  logic signed [32:0] gs, gr, go;
  logic signed [47:0] t1, t2;
  logic we_ent, we_rel;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign used      = 8'(scalar_count) + {1'b0, pair_count, 1'b0};
  assign over      = used > 8'(DIM);
  assign dd        = 8'(dim);
  assign mid       = 8'(scalar_count) + 8'(pair_count);
  assign partner   = (dd >= mid) ? dd - 8'(pair_count) : dd + 8'(pair_count);
  assign dim_last  = (dim == DIM_W'(DIM - 1));
  assign rcol      = (state == ST_OWN) ? dim : par_col;
  assign term      = im ? 49'(t1) - 49'(t2) : 49'(t1) + 49'(t2);
  assign acc_next  = acc + 54'(term);

  assign we_ent = in_fire && func == FN_WENT && int'(subj) < NUM_ENTITIES
                  && int'(column) < DIM;
  assign we_rel = in_fire && func == FN_WREL && int'(rel) < NUM_RELATIONS
                  && int'(column) < DIM;

  always_comb begin
    ctl         = '0;
    ctl.im      = im;
    ctl.own_ld  = (state == ST_PAR);
    ctl.prod_en = (state == ST_MUL);
    ctl.sum_en  = (state == ST_SUM);
    if (state == ST_PAR) begin
      ctl.s_keep = s_ok && !own_zero;
      ctl.r_keep = r_ok && !own_zero;
      ctl.o_keep = o_ok && !own_zero;
    end else begin
      ctl.s_keep = s_ok && !par_zero;
      ctl.r_keep = r_ok && !par_zero;
      ctl.o_keep = o_ok && !par_zero;
    end
  end

  ats_tables u_tables (
    .clk    (clk),
    .we_ent (we_ent),
    .we_rel (we_rel),
    .wa_ent (ENT_AW'(int'(subj) * DIM + int'(column))),
    .wa_rel (REL_AW'(int'(rel) * DIM + int'(column))),
    .wdata  (value),
    .ra_s   (ENT_AW'(int'(subj_q) * DIM + int'(rcol))),
    .ra_o   (ENT_AW'(int'(obj_q) * DIM + int'(rcol))),
    .ra_r   (REL_AW'(int'(rel_q) * DIM + int'(rcol))),
    .rd_s   (rd_s),
    .rd_o   (rd_o),
    .rd_r   (rd_r)
  );

  ats_datapath u_datapath (
    .clk  (clk),
    .ctl  (ctl),
    .rd_s (rd_s),
    .rd_o (rd_o),
    .rd_r (rd_r),
    .gs   (gs),
    .gr   (gr),
    .go   (go),
    .t1   (t1),
    .t2   (t2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      scalar_count <= 7'd0;
      pair_count   <= 6'd32;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SCALAR: scalar_count <= cfg_data;
        CFG_PAIR:   pair_count   <= cfg_data[5:0];
        default:    scalar_count <= scalar_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      err       <= 1'b0;
      is_grad   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire && func[1]) begin
            is_grad <= (func == FN_GRAD);
            err     <= over;
            subj_q  <= subj;
            rel_q   <= rel;
            obj_q   <= obj;
            s_ok    <= int'(subj) < NUM_ENTITIES;
            r_ok    <= int'(rel) < NUM_RELATIONS;
            o_ok    <= int'(obj) < NUM_ENTITIES;
            dim     <= '0;
            acc     <= '0;
            state   <= over ? ST_EMIT : ST_OWN;
          end
        end
        ST_OWN: begin
          own_zero <= dd >= used;
          par_zero <= dd < 8'(scalar_count) || dd >= used;
          im       <= dd >= mid && dd < used;
          par_col  <= partner[DIM_W-1:0];
          state    <= ST_PAR;
        end
        ST_PAR: state <= ST_MUL;
        ST_MUL: state <= ST_SUM;
        ST_SUM: state <= ST_EMIT;
        ST_EMIT: begin
          if (err) begin
            if (out_free) begin
              out_valid <= 1'b1;
              score_sum <= '0;
              grad_subj <= '0;
              grad_rel  <= '0;
              grad_obj  <= '0;
              dim_index <= 6'd0;
              last      <= 1'b1;
              status    <= 1'b1;
              state     <= ST_IDLE;
            end
          end else if (is_grad) begin
            if (out_free) begin
              out_valid <= 1'b1;
              score_sum <= '0;
              grad_subj <= gs;
              grad_rel  <= gr;
              grad_obj  <= go;
              dim_index <= 6'(dim);
              last      <= dim_last;
              status    <= 1'b0;
              dim       <= dim + 1'b1;
              state     <= dim_last ? ST_IDLE : ST_OWN;
            end
          end else if (!dim_last) begin
            acc   <= acc_next;
            dim   <= dim + 1'b1;
            state <= ST_OWN;
          end else if (out_free) begin
            out_valid <= 1'b1;
            score_sum <= acc_next;
            grad_subj <= '0;
            grad_rel  <= '0;
            grad_obj  <= '0;
            dim_index <= 6'd0;
            last      <= 1'b1;
            status    <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLY(a_err_path, clk, rst, (in_fire && func[1] && over) |=> (state == ST_EMIT && err))
  `ASSERT_IMPLY(a_grad_end, clk, rst, (state == ST_EMIT && is_grad && !err && out_free && dim_last) |=> (out_valid && last && state == ST_IDLE))
  `ASSERT_NEVER(a_no_take_busy, clk, rst, in_ready && state != ST_IDLE)
endmodule

// ----- test/tb_top.sv -----
module tb_top;
  import ats_pkg::*;

  typedef struct packed {
    logic signed [53:0] score;
    logic signed [32:0] gs;
    logic signed [32:0] gr;
    logic signed [32:0] go;
    logic [5:0]         dim;
    logic               last;
    logic               status;
  } beat_t;

  class triple_scoreboard;
    word_t ent_words [NUM_ENTITIES*DIM];
    word_t rel_words [NUM_RELATIONS*DIM];
    int unsigned scalar_cnt = 0;
    int unsigned pair_cnt = 32;
    beat_t expected_beats [$];
    int errors = 0;

    function longint ew(int row, int c);
      return longint'(ent_words[row*DIM + c]);
    endfunction

    function longint rw(int row, int c);
      return longint'(rel_words[row*DIM + c]);
    endfunction

    function void set_config(logic idx, logic [6:0] data);
      if (idx == CFG_SCALAR) scalar_cnt = data;
      else pair_cnt = data[5:0];
    endfunction

    function void note_input(logic [1:0] f, logic [9:0] s, logic [5:0] r, logic [9:0] o,
                             logic [5:0] col, word_t val);
      beat_t b;
      longint sum, rre, rim, sre, sim, ore, oim;
      longint gs [DIM];
      longint gr [DIM];
      longint go [DIM];
      int m;
      b = '0;
      if (f == FN_WENT) begin
        ent_words[s*DIM + col] = val;
        return;
      end
      if (f == FN_WREL) begin
        rel_words[r*DIM + col] = val;
        return;
      end
      if (scalar_cnt + 2*pair_cnt > DIM) begin
        b.last = 1;
        b.status = 1;
        expected_beats.push_back(b);
        return;
      end
      for (int i = 0; i < DIM; i++) begin
        gs[i] = 0;
        gr[i] = 0;
        go[i] = 0;
      end
      sum = 0;
      for (int i = 0; i < scalar_cnt; i++) begin
        sum += ew(s, i) * rw(r, i) * ew(o, i);
        gs[i] = rw(r, i) * ew(o, i);
        gr[i] = ew(s, i) * ew(o, i);
        go[i] = ew(s, i) * rw(r, i);
      end
      for (int i = scalar_cnt; i < scalar_cnt + pair_cnt; i++) begin
        m = i + pair_cnt;
        rre = rw(r, i); rim = rw(r, m);
        sre = ew(s, i); sim = ew(s, m);
        ore = ew(o, i); oim = ew(o, m);
        sum += rre*sre*ore + rre*sim*oim + rim*sre*oim - rim*sim*ore;
        gs[i] = rre*ore + rim*oim;
        gr[i] = sre*ore + sim*oim;
        go[i] = rre*sre - rim*sim;
        gs[m] = rre*oim - rim*ore;
        gr[m] = sre*oim - sim*ore;
        go[m] = rre*sim + rim*sre;
      end
      if (f == FN_SCORE) begin
        b.score = 54'(sum);
        b.last = 1;
        expected_beats.push_back(b);
      end else begin
        for (int i = 0; i < DIM; i++) begin
          b.gs = 33'(gs[i]);
          b.gr = 33'(gr[i]);
          b.go = 33'(go[i]);
          b.dim = 6'(i);
          b.last = (i == DIM - 1);
          expected_beats.push_back(b);
        end
      end
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch %s: got %0h expected %0h", what, got, want);
    endtask

    task check_result(beat_t got);
      beat_t want;
      if (expected_beats.size() == 0) begin
        report("unexpected beat", got.dim, 0);
        return;
      end
      want = expected_beats.pop_front();
      if (got.score !== want.score) report("score_sum", got.score, want.score);
      if (got.gs !== want.gs) report("grad_subj", got.gs, want.gs);
      if (got.gr !== want.gr) report("grad_rel", got.gr, want.gr);
      if (got.go !== want.go) report("grad_obj", got.go, want.go);
      if (got.dim !== want.dim) report("dim_index", got.dim, want.dim);
      if (got.last !== want.last) report("last", got.last, want.last);
      if (got.status !== want.status) report("status", got.status, want.status);
    endtask
  endclass

  localparam int STALL_LIMIT = 20000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic cfg_index = 0;
  logic [6:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] func = FN_WENT;
  logic [9:0] subj = '0;
  logic [5:0] rel = '0;
  logic [9:0] obj = '0;
  logic [5:0] column = '0;
  logic signed [15:0] value = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [53:0] score_sum;
  logic signed [32:0] grad_subj, grad_rel, grad_obj;
  logic [5:0] dim_index;
  logic last, status;

  triple_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  logic [9:0] ent_pool [3];
  logic [5:0] rel_pool [2];

  analogy_triple_scorer_core dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result({score_sum, grad_subj, grad_rel, grad_obj, dim_index, last, status});
    if (hold_req) begin
      hold_left = 2000;
      hold_req = 0;
    end
    if (hold_left > 0) hold_left--;
    out_ready <= !rst && hold_left == 0 && $urandom_range(99) >= recv_stall_pct;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic write_cfg(logic idx, logic [6:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_config(idx, data);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic send(logic [1:0] f, logic [9:0] s, logic [5:0] r, logic [9:0] o,
                      logic [5:0] col, logic signed [15:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    func <= f;
    subj <= s;
    rel <= r;
    obj <= o;
    column <= col;
    value <= val;
    do @(posedge clk); while (!in_ready);
    sb.note_input(f, s, r, o, col, val);
  endtask

  task automatic drain();
    if (in_valid) begin
      in_valid <= 0;
      @(posedge clk);
    end
    while (sb.expected_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15)
      send(FN_WENT, $urandom_range(9) == 0 ? 10'($urandom) : ent_pool[$urandom_range(2)],
           6'($urandom), 10'($urandom), 6'($urandom), 16'($urandom));
    else if (pick < 28)
      send(FN_WREL, 10'($urandom),
           $urandom_range(4) == 0 ? 6'($urandom) : rel_pool[$urandom_range(1)],
           10'($urandom), 6'($urandom), 16'($urandom));
    else
      send(pick < 65 ? FN_SCORE : FN_GRAD, ent_pool[$urandom_range(2)],
           rel_pool[$urandom_range(1)], ent_pool[$urandom_range(2)], 6'($urandom),
           16'($urandom));
  endtask

  initial begin
    logic [6:0] phase_scalar [8];
    logic [6:0] phase_pair [8];
    int idle_mode [4][2];

    phase_scalar = '{0, 64, 0, 10, 1, 127, 20, 33};
    phase_pair = '{32, 0, 0, 27, 32, 63, 5, 15};
    idle_mode = '{'{0, 0}, '{47, 0}, '{0, 47}, '{37, 37}};
    ent_pool = '{10'd0, 10'd1023, 10'($urandom_range(1, 1022))};
    rel_pool = '{6'd0, 6'($urandom_range(1, 63))};
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    for (int c = 0; c < DIM; c++) begin
      send(FN_WENT, ent_pool[0], 0, 0, 6'(c), -16'sd32768);
      send(FN_WENT, ent_pool[1], 0, 0, 6'(c), 16'sd32767);
      send(FN_WENT, ent_pool[2], 0, 0, 6'(c), 16'($urandom));
      send(FN_WREL, 0, rel_pool[0], 0, 6'(c), -16'sd32768);
      send(FN_WREL, 0, rel_pool[1], 0, 6'(c), 16'($urandom));
    end

    send(FN_SCORE, ent_pool[0], rel_pool[0], ent_pool[0], 0, 0);
    send(FN_SCORE, ent_pool[1], rel_pool[1], ent_pool[1], 6'h3f, -16'sd1);
    send(FN_SCORE, ent_pool[0], rel_pool[0], ent_pool[1], 0, 0);
    send(FN_GRAD, ent_pool[0], rel_pool[0], ent_pool[1], 0, 0);
    send(FN_GRAD, ent_pool[1], rel_pool[1], ent_pool[0], 0, 0);
    send(FN_SCORE, ent_pool[2], rel_pool[1], ent_pool[2], 0, 0);
    drain();

    for (int p = 0; p < 8; p++) begin
      write_cfg(CFG_SCALAR, phase_scalar[p]);
      write_cfg(CFG_PAIR, phase_pair[p]);
      send_idle_pct = idle_mode[p % 4][0];
      recv_stall_pct = idle_mode[p % 4][1];
      send(FN_SCORE, ent_pool[1], rel_pool[1], ent_pool[0], 0, 0);
      send(FN_GRAD, ent_pool[0], rel_pool[1], ent_pool[1], 0, 0);
      for (int n = 0; n < 16; n++) begin
        if (p == 2 && n == 5) hold_req = 1;
        random_item();
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule
